// ===== rtl/core/lsr_pkg.sv =====
// Shared constants, types and constant functions for the look-and-say run encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int SYMBOL_W    = 8;

	localparam longint unsigned DECIMAL_CAP = 64'd999999999;
	localparam longint unsigned COUNT_RAW   = (64'd1 << COUNT_WIDTH) - 64'd1;
	localparam longint unsigned COUNT_LIM64 = (COUNT_RAW < DECIMAL_CAP) ? COUNT_RAW : DECIMAL_CAP;
	localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = COUNT_LIM64[COUNT_WIDTH-1:0];

	// Decimal digits needed for the largest count.
	function automatic int num_digits_f(longint unsigned lim);
		longint unsigned p;
		int n;
		p = 64'd10;
		n = 1;
		for (int i = 0; i < 10; i++) begin
			if (p <= lim) begin
				n = n + 1;
				p = p * 64'd10;
			end
		end
		return n;
	endfunction

	function automatic longint unsigned pow10_f(int k);
		longint unsigned p;
		p = 64'd1;
		for (int i = 0; i < k; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

	localparam int NUM_DIGITS = num_digits_f(COUNT_LIM64);
	localparam int POS_W      = $clog2(NUM_DIGITS);
	// Room for nine times the highest place value.
	localparam int EXT_W      = COUNT_WIDTH + 4;

	localparam logic [SYMBOL_W-1:0] ASCII_ZERO = 8'h30;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One finished run, handed from the front end to the digit emitter.
	typedef struct packed {
		logic [SYMBOL_W-1:0]    run_char;
		logic [COUNT_WIDTH-1:0] run_count;
		logic                   string_last;
		logic                   run_last;
	} run_job_t;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_DIGIT = 3'b010,
		BK_CHAR  = 3'b100
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsr_if.sv =====
// Valid/ready channel interfaces for the run encoder input and output streams.
// Depends on lsr_pkg for the symbol width.
`timescale 1ns / 1ps
`default_nettype none

interface lsr_in_if;
	import lsr_pkg::*;
	logic                valid;
	logic                ready;
	logic [SYMBOL_W-1:0] symbol;
	logic                end_of_string;

	modport source (output valid, output symbol, output end_of_string, input ready);
	modport sink   (input valid, input symbol, input end_of_string, output ready);
endinterface

interface lsr_out_if;
	import lsr_pkg::*;
	logic                valid;
	logic                ready;
	logic [SYMBOL_W-1:0] out_char;
	logic                run_last;
	logic                string_last;

	modport source (output valid, output out_char, output run_last, output string_last,
		input ready);
	modport sink   (input valid, input out_char, input run_last, input string_last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/look_and_say_run_encoder.sv =====
// Look-and-say run encoder: top level joining the front end, job queue and digit emitter.
// Depends on lsr_pkg, lsr_if, lsr_front, lsr_queue and lsr_back.
//
// Each accepted character either extends the open run or closes it; a closed run comes out
// as its count in decimal ASCII digits, most significant first, followed by the run
// character, and the end-of-string flag also closes the final run and marks its character
// with string_last. The input takes one character per cycle while the job queue has room;
// a character that both changes the run and ends the string holds the input off until
// the second of its two jobs is posted. The digit emitter produces one output character
// per cycle while the receiver does not stall it, each run coming out as its digits, found
// by the emitter's place-value compare and subtract, then its character; the sustained
// input rate is therefore set by the output expansion. Counts saturate at 65535. There is
// no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module look_and_say_run_encoder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lsr_in_if.sink     in_ch,
	lsr_out_if.source  out_ch
);
	import lsr_pkg::*;

	logic     push_valid;
	run_job_t push_job;
	logic     q_full;
	logic     q_empty;
	logic     pop;
	run_job_t head;

	lsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	lsr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	lsr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

// ===== rtl/core/lsr_front.sv =====
// Front end: accepts characters, tracks the open run and posts finished runs as jobs.
// Depends on lsr_pkg and lsr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module lsr_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lsr_in_if.sink            in_ch,
	output logic              push_valid,
	output lsr_pkg::run_job_t push_job,
	input  wire logic         q_full
);
	import lsr_pkg::*;

	logic [SYMBOL_W-1:0]    char_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   active_q;
	logic                   pend_q;
	run_job_t               pend_job_q;

	logic                   accept;
	logic                   same;
	logic                   change;
	logic [SYMBOL_W-1:0]    new_char;
	logic [COUNT_WIDTH-1:0] new_count;
	run_job_t               chg_job;
	run_job_t               eos_job;

	assign in_ch.ready = !pend_q && !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		same   = active_q && (in_ch.symbol == char_q);
		change = active_q && !same;
		if (same) begin
			new_char  = char_q;
			new_count = (count_q < COUNT_LIMIT) ? COUNT_WIDTH'(count_q + 1'b1) : count_q;
		end else begin
			new_char  = in_ch.symbol;
			new_count = COUNT_WIDTH'(1);
		end
		chg_job.run_char    = char_q;
		chg_job.run_count   = count_q;
		chg_job.string_last = 1'b0;
		chg_job.run_last    = !in_ch.end_of_string;
		eos_job.run_char    = new_char;
		eos_job.run_count   = new_count;
		eos_job.string_last = 1'b1;
		eos_job.run_last    = 1'b1;
	end

	// Hold the pending job until the queue has room.
	assign push_valid = (pend_q && !q_full) || (accept && (change || in_ch.end_of_string));
	assign push_job   = pend_q ? pend_job_q : (change ? chg_job : eos_job);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q   <= '0;
			count_q  <= '0;
			active_q <= 1'b0;
			pend_q   <= 1'b0;
		end else if (accept) begin
			if (in_ch.end_of_string) begin
				char_q   <= '0;
				count_q  <= '0;
				active_q <= 1'b0;
			end else begin
				char_q   <= new_char;
				count_q  <= new_count;
				active_q <= 1'b1;
			end
			// A change and an end flag together leave the final run pending until the queue has room.
			pend_q <= change && in_ch.end_of_string;
		end else if (pend_q && !q_full) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_job_q <= eos_job;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lsr_queue.sv =====
// Short job queue between the front end and the digit emitter.
// Depends on lsr_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module lsr_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lsr_pkg::run_job_t push_job,
	output logic                   full,
	input  wire logic              pop,
	output logic                   empty,
	output lsr_pkg::run_job_t      head
);
	import lsr_pkg::*;

	run_job_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= (QPTR_W+1)'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= (QPTR_W+1)'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == (QPTR_W+1)'($past(count_q) + 1'b1)))
		else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lsr_back.sv =====
// Back end (uses lsr_pkg): turns a run job into decimal count digits, most significant
// first, then the run character, one per cycle unless stalled, to a registered output.
`timescale 1ns / 1ps
`default_nettype none

module lsr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire lsr_pkg::run_job_t head,
	output logic                   pop,
	lsr_out_if.source              out_ch
);
	import lsr_pkg::*;

	back_state_t            state_q;
	logic [POS_W-1:0]       pos_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [SYMBOL_W-1:0]    char_q;
	logic                   str_last_q;
	logic                   run_last_q;
	logic                   out_valid_q;
	logic [SYMBOL_W-1:0]    out_char_q;
	logic                   out_rlast_q;
	logic                   out_slast_q;

	logic [EXT_W-1:0]       mult_tab [NUM_DIGITS][10];
	logic                   advance;
	logic                   emit;
	logic [3:0]             digit;
	logic [EXT_W-1:0]       rem_ext;
	logic [COUNT_WIDTH-1:0] rem_next;
	logic [POS_W-1:0]       start_pos;

	// d times ten to the k, constant per place and digit.
	for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_place
		for (genvar d = 0; d < 10; d++) begin : g_dig
			assign mult_tab[k][d] = EXT_W'(64'(d) * pow10_f(k));
		end
	end

	assign advance = !out_valid_q || out_ch.ready;
	assign emit    = advance && ((state_q == BK_DIGIT) || (state_q == BK_CHAR));
	assign pop     = !q_empty && ((state_q == BK_IDLE) || ((state_q == BK_CHAR) && advance));

	always_comb begin
		rem_ext = EXT_W'(rem_q);
		digit   = 4'd0;
		for (int d = 1; d < 10; d++) begin
			if (rem_ext >= mult_tab[pos_q][d]) begin
				digit = 4'(d);
			end
		end
		rem_next = COUNT_WIDTH'(rem_ext - mult_tab[pos_q][digit]);
	end

	// Highest place with a nonzero digit; no leading zeros.
	always_comb begin
		start_pos = '0;
		for (int k = 1; k < NUM_DIGITS; k++) begin
			if (EXT_W'(head.run_count) >= mult_tab[k][1]) begin
				start_pos = POS_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						state_q <= BK_DIGIT;
					end
				end
				BK_DIGIT: begin
					if (advance) begin
						if (pos_q == '0) begin
							state_q <= BK_CHAR;
						end
					end
				end
				BK_CHAR: begin
					if (advance) begin
						state_q <= pop ? BK_DIGIT : BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q      <= head.run_count;
			pos_q      <= start_pos;
			char_q     <= head.run_char;
			str_last_q <= head.string_last;
			run_last_q <= head.run_last;
		end
		if ((state_q == BK_DIGIT) && advance) begin
			out_char_q  <= ASCII_ZERO + SYMBOL_W'(digit);
			out_rlast_q <= 1'b0;
			out_slast_q <= 1'b0;
			rem_q       <= rem_next;
			if (pos_q != '0) begin
				pos_q <= POS_W'(pos_q - 1'b1);
			end
		end
		if ((state_q == BK_CHAR) && advance) begin
			out_char_q  <= char_q;
			out_rlast_q <= run_last_q;
			out_slast_q <= str_last_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_char    = out_char_q;
	assign out_ch.run_last    = out_rlast_q;
	assign out_ch.string_last = out_slast_q;

`ifndef SYNTHESIS
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIGIT) |-> (digit <= 4'd9))
		else $error("count digit out of range");
	a_string_last_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_slast_q) |-> out_rlast_q)
		else $error("string end without item end");
	a_pop_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> ((state_q == BK_IDLE) || (state_q == BK_CHAR)))
		else $error("job taken mid-run");
`endif

endmodule

`default_nettype wire

// ===== dv/lsr_stream_checker.sv =====
// Scoreboard for the look-and-say run encoder: watches both channels, predicts the stream.
// Depends on lsr_pkg for widths, the count width and the ASCII zero code.
`timescale 1ns / 1ps

module lsr_stream_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sym_valid,
	input  wire logic                         sym_ready,
	input  wire logic [lsr_pkg::SYMBOL_W-1:0] symbol,
	input  wire logic                         end_of_string,
	input  wire logic                         enc_valid,
	input  wire logic                         enc_ready,
	input  wire logic [lsr_pkg::SYMBOL_W-1:0] enc_char,
	input  wire logic                         run_last,
	input  wire logic                         string_last,
	output int                                error_count,
	output int                                pending_count
);
	import lsr_pkg::*;

	localparam longint unsigned DECIMAL_BASE = 64'd10;
	localparam longint unsigned FULL_COUNT   = (64'd1 << COUNT_WIDTH) - 64'd1;
	// Counts stop at the lower of the register's full scale and nine decimal digits.
	localparam longint unsigned SAT_COUNT    =
		(FULL_COUNT < 64'd999999999) ? FULL_COUNT : 64'd999999999;

	typedef struct packed {
		logic [SYMBOL_W-1:0] out_char;
		logic                run_last;
		logic                string_last;
	} enc_result_t;

	enc_result_t            expected_chars[$];
	logic [SYMBOL_W-1:0]    open_char;
	logic [COUNT_WIDTH-1:0] open_count;
	bit                     run_open;

	// Append the count digits, most significant first, then the run character.
	function automatic void queue_run(bit closes_string);
		logic [SYMBOL_W-1:0] digit_chars[10];
		int                  nd;
		longint unsigned     c;
		enc_result_t         item;
		c  = (open_count == '0) ? 64'd1 : longint'(open_count);
		nd = 0;
		while (c != 0 && nd < 10) begin
			digit_chars[nd] = ASCII_ZERO + SYMBOL_W'(c % DECIMAL_BASE);
			c = c / DECIMAL_BASE;
			nd++;
		end
		while (nd > 0) begin
			nd--;
			item = '{out_char: digit_chars[nd], run_last: 1'b0, string_last: 1'b0};
			expected_chars.insert(expected_chars.size(), item);
		end
		item = '{out_char: open_char, run_last: 1'b0, string_last: closes_string};
		expected_chars.insert(expected_chars.size(), item);
	endfunction

	function automatic void encode_symbol(logic [SYMBOL_W-1:0] sym, logic eos);
		int          queued;
		enc_result_t tail;
		queued = expected_chars.size();
		if (!run_open) begin
			open_char  = sym;
			open_count = COUNT_WIDTH'(1);
			run_open   = 1'b1;
		end else if (sym == open_char) begin
			if (longint'(open_count) < SAT_COUNT)
				open_count = open_count + 1'b1;
		end else begin
			queue_run(1'b0);
			open_char  = sym;
			open_count = COUNT_WIDTH'(1);
		end
		if (eos) begin
			queue_run(1'b1);
			run_open   = 1'b0;
			open_count = '0;
			open_char  = '0;
		end
		// Mark the final character this transfer produced.
		if (expected_chars.size() > queued) begin
			tail = expected_chars.pop_back();
			tail.run_last = 1'b1;
			expected_chars.insert(expected_chars.size(), tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		enc_result_t want;
		if (!arst_n) begin
			expected_chars.delete();
			open_char     = '0;
			open_count    = '0;
			run_open      = 1'b0;
			error_count   = 0;
			pending_count = 0;
		end else begin
			if (sym_valid && sym_ready)
				encode_symbol(symbol, end_of_string);
			if (enc_valid && enc_ready) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected result: out_char %0h run_last %0b string_last %0b",
						enc_char, run_last, string_last);
					error_count++;
				end else begin
					want = expected_chars.pop_front();
					if (enc_char !== want.out_char) begin
						$error("out_char: expected %0h, actual %0h", want.out_char, enc_char);
						error_count++;
					end
					if (run_last !== want.run_last) begin
						$error("run_last: expected %0b, actual %0b", want.run_last, run_last);
						error_count++;
					end
					if (string_last !== want.string_last) begin
						$error("string_last: expected %0b, actual %0b", want.string_last,
							string_last);
						error_count++;
					end
				end
			end
			pending_count = expected_chars.size();
		end
	end

endmodule

// ===== dv/look_and_say_run_encoder_test.sv =====
// Testbench top for the look-and-say run encoder: clock, reset, strings and output stalls.
// Depends on lsr_pkg, lsr_if, the encoder RTL and lsr_stream_checker.
`timescale 1ns / 1ps

module look_and_say_run_encoder_test;
	import lsr_pkg::*;

	localparam int  CYCLE_LIMIT  = 1000000;
	localparam int  HOLD_CYCLES  = 400;
	localparam int  RANDOM_ITEMS = 500;

	logic clk;
	logic arst_n;
	int   error_count;
	int   pending_count;
	int   cycle_count;
	int   symbols_sent;
	int   hold_requests;
	int   holds_served;
	bit   steady_sender;

	lsr_in_if  sym_ch ();
	lsr_out_if enc_ch ();

	look_and_say_run_encoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (sym_ch),
		.out_ch (enc_ch)
	);

	lsr_stream_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.sym_valid     (sym_ch.valid),
		.sym_ready     (sym_ch.ready),
		.symbol        (sym_ch.symbol),
		.end_of_string (sym_ch.end_of_string),
		.enc_valid     (enc_ch.valid),
		.enc_ready     (enc_ch.ready),
		.enc_char      (enc_ch.out_char),
		.run_last      (enc_ch.run_last),
		.string_last   (enc_ch.string_last),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Offer one character and hold it until the transfer.
	task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic eos);
		int gap;
		gap = steady_sender ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			sym_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sym_ch.valid         <= 1'b1;
		sym_ch.symbol        <= sym;
		sym_ch.end_of_string <= eos;
		@(posedge clk);
		while (!sym_ch.ready) @(posedge clk);
		@(negedge clk);
		symbols_sent++;
	endtask

	task automatic drain;
		sym_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
	endtask

	// One string made of runs, or now and then a stretch of raw noise.
	task automatic send_string;
		int                  runs;
		int                  len;
		int                  pick;
		bit                  narrow;
		logic [SYMBOL_W-1:0] base;
		logic [SYMBOL_W-1:0] ch;
		if ($urandom_range(0, 7) == 0) begin
			len = $urandom_range(1, 10);
			for (int i = 0; i < len; i++)
				send_symbol(SYMBOL_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		end else begin
			runs   = $urandom_range(1, 6);
			narrow = $urandom_range(0, 1);
			base   = SYMBOL_W'($urandom_range(0, 255));
			for (int r = 0; r < runs; r++) begin
				ch   = narrow ? base + SYMBOL_W'($urandom_range(0, 3))
					: SYMBOL_W'($urandom_range(0, 255));
				pick = $urandom_range(0, 19);
				if (pick < 12)
					len = $urandom_range(1, 3);
				else if (pick < 17)
					len = $urandom_range(4, 9);
				else if (pick < 19)
					len = $urandom_range(10, 12);
				else
					len = $urandom_range(98, 102);
				for (int i = 0; i < len; i++)
					send_symbol(ch, r == runs - 1 && i == len - 1);
			end
		end
	endtask

	// Receiver: random stalls per result, quiet stretches, and one long hold-off on request.
	initial begin
		int  stall;
		int  taken;
		bit  quiet;
		taken = 0;
		quiet = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				enc_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (taken % 32 == 0)
				quiet = $urandom_range(0, 3) == 0;
			stall = quiet ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				enc_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			enc_ch.ready <= 1'b1;
			@(posedge clk);
			while (!enc_ch.valid) @(posedge clk);
			@(negedge clk);
			taken++;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("look_and_say_run_encoder_test failed");
		$finish;
	end

	initial begin
		int strings_done;
		sym_ch.valid         = 1'b0;
		sym_ch.symbol        = '0;
		sym_ch.end_of_string = 1'b0;
		enc_ch.ready         = 1'b0;
		arst_n               = 1'b0;
		symbols_sent         = 0;
		hold_requests        = 0;
		holds_served         = 0;
		steady_sender        = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Single flagged character, extreme bytes, change together with the end flag,
		// end flag on a repeat, a two-digit count, digit characters as run characters.
		send_symbol("A", 1'b1);
		repeat (3) send_symbol(8'h00, 1'b0);
		send_symbol(8'hFF, 1'b1);
		send_symbol("B", 1'b0);
		send_symbol("B", 1'b1);
		repeat (10) send_symbol(8'hAA, 1'b0);
		send_symbol(8'h55, 1'b1);
		send_symbol("0", 1'b0);
		send_symbol("1", 1'b0);
		send_symbol("1", 1'b1);
		drain();

		symbols_sent = 0;
		strings_done = 0;
		while (symbols_sent < RANDOM_ITEMS) begin
			if (strings_done == 5) begin
				// Keep offering single-character runs while the output is held off.
				hold_requests++;
				steady_sender = 1'b1;
				for (int i = 0; i < 40; i++)
					send_symbol(SYMBOL_W'(8'h41 + (i % 2)), i == 39);
			end
			steady_sender = $urandom_range(0, 3) == 0;
			send_string();
			strings_done++;
			if (strings_done % 8 == 0)
				drain();
		end
		send_symbol(SYMBOL_W'($urandom_range(0, 255)), 1'b1);
		drain();
		repeat (20) @(negedge clk);

		if (error_count == 0)
			$display("look_and_say_run_encoder_test passed");
		else
			$display("look_and_say_run_encoder_test failed");
		$finish;
	end

endmodule
